// File: design/esbk_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// esbk_pkg: shared types and constants of the exchange sort block
// Command flags passed from the front end to the sorting engine, and the
// fixed widths of the stream fields.
// ============================================================================
package esbk_pkg;

    localparam int IN_KEY_W    = 32;
    localparam int OUT_TAG_W   = 6;
    localparam int OUT_KEY_W   = 32;
    localparam int OUT_DATA_W  = 40;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic store;
        logic last;
    } t_cmd_ctl;

endpackage

// File: design/esbk_front.sv
`timescale 1ns / 1ps
// ============================================================================
// esbk_front: input classification
// Takes input words, tags each with its arrival index and marks whether it
// fits into the store and whether it closes the list.
// ============================================================================
module esbk_front #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [esbk_pkg::IN_KEY_W-1:0]       i_key_value,
    input  logic                                i_is_last,
    output logic                                o_push,
    input  logic                                i_full,
    output esbk_pkg::t_cmd_ctl                  o_ctl,
    output logic [$clog2(MAX_ENTRIES)-1:0]      o_tag,
    output logic [KEY_BITS-1:0]                 o_key
);

    localparam int TAG_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_room;

    assign o_ready   = !i_full;
    assign o_push    = i_valid && !i_full;
    assign w_room    = (r_count != CNT_W'(MAX_ENTRIES));
    assign o_ctl.store = w_room;
    assign o_ctl.last  = i_is_last;
    assign o_tag     = r_count[TAG_W-1:0];
    assign o_key     = KEY_BITS'(i_key_value);

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            if (i_is_last) begin
                n_count = '0;
            end else if (w_room) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// File: design/esbk_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// esbk_queue: command queue
// A short first-in first-out queue that decouples the front end from the
// sorting engine.
// ============================================================================
module esbk_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: design/esbk_back.sv
`timescale 1ns / 1ps
// ============================================================================
// esbk_back: store and exchange sort engine
// Writes entries into the store, runs the exchange sort over it with one
// read and one write a cycle, and streams the sorted entries out.
// ============================================================================
module esbk_back #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    output logic                                o_q_pop,
    input  esbk_pkg::t_cmd_ctl                  i_q_ctl,
    input  logic [$clog2(MAX_ENTRIES)-1:0]      i_q_tag,
    input  logic [KEY_BITS-1:0]                 i_q_key,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [esbk_pkg::OUT_TAG_W-1:0]      o_origin_index,
    output logic [esbk_pkg::OUT_KEY_W-1:0]      o_key_value,
    output logic                                o_overflowed,
    output logic                                o_last
);

    localparam int TAG_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = TAG_W + KEY_BITS;

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_START = 6'b000010,
        ST_LDI   = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_WRI   = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    logic [ENT_W-1:0] r_mem [MAX_ENTRIES];
    logic [ENT_W-1:0] r_rd_data;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [TAG_W-1:0] r_i, n_i;
    logic [TAG_W-1:0] r_j, n_j;
    logic [TAG_W-1:0] r_k, n_k;
    logic [ENT_W-1:0] r_cur, n_cur;
    logic             r_p1_valid, n_p1_valid;
    logic             r_p1_last, n_p1_last;
    logic             r_p1_ovf, n_p1_ovf;
    logic             r_out_valid;
    logic [esbk_pkg::OUT_TAG_W-1:0] r_out_tag;
    logic [esbk_pkg::OUT_KEY_W-1:0] r_out_key;
    logic             r_out_ovf;
    logic             r_out_last;

    logic             w_we;
    logic [TAG_W-1:0] w_wa;
    logic [ENT_W-1:0] w_wd;
    logic             w_rd_en;
    logic [TAG_W-1:0] w_ra;
    logic             w_adv;
    logic             w_emit_rd;
    logic [TAG_W-1:0] w_last_idx;
    logic             w_swap;

    assign w_adv      = !r_out_valid || i_ready;
    assign w_emit_rd  = (r_state == ST_EMIT) && (!r_p1_valid || w_adv);
    assign w_last_idx = TAG_W'(r_count - CNT_W'(1));
    assign w_swap     = r_cur[KEY_BITS-1:0] > r_rd_data[KEY_BITS-1:0];

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_cur      = r_cur;
        n_p1_last  = r_p1_last;
        n_p1_ovf   = r_p1_ovf;
        n_p1_valid = w_emit_rd || (r_p1_valid && !w_adv);
        w_we       = 1'b0;
        w_wa       = '0;
        w_wd       = r_cur;
        w_rd_en    = 1'b0;
        w_ra       = '0;
        o_q_pop    = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    if (i_q_ctl.store) begin
                        w_we    = 1'b1;
                        w_wa    = i_q_tag;
                        w_wd    = {i_q_tag, i_q_key};
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_q_ctl.last) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                if (!r_p1_valid) begin
                    n_i = '0;
                    n_k = '0;
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_EMIT;
                    end else begin
                        w_rd_en = 1'b1;
                        w_ra    = '0;
                        n_state = ST_LDI;
                    end
                end
            end
            ST_LDI: begin
                n_cur   = r_rd_data;
                w_rd_en = 1'b1;
                w_ra    = r_i + TAG_W'(1);
                n_j     = r_i + TAG_W'(1);
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_swap) begin
                    w_we  = 1'b1;
                    w_wa  = r_j;
                    w_wd  = r_cur;
                    n_cur = r_rd_data;
                end
                if (r_j == w_last_idx) begin
                    n_state = ST_WRI;
                end else begin
                    w_rd_en = 1'b1;
                    w_ra    = r_j + TAG_W'(1);
                    n_j     = r_j + TAG_W'(1);
                end
            end
            ST_WRI: begin
                w_we = 1'b1;
                w_wa = r_i;
                w_wd = r_cur;
                if (r_i + TAG_W'(1) == w_last_idx) begin
                    n_k     = '0;
                    n_state = ST_EMIT;
                end else begin
                    w_rd_en = 1'b1;
                    w_ra    = r_i + TAG_W'(1);
                    n_i     = r_i + TAG_W'(1);
                    n_state = ST_LDI;
                end
            end
            ST_EMIT: begin
                if (w_emit_rd) begin
                    w_rd_en   = 1'b1;
                    w_ra      = r_k;
                    n_p1_last = (r_k == w_last_idx);
                    n_p1_ovf  = r_ovf;
                    if (r_k == w_last_idx) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_k = r_k + TAG_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_p1_valid <= n_p1_valid;
            if (w_adv) begin
                r_out_valid <= r_p1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_k       <= n_k;
        r_cur     <= n_cur;
        r_p1_last <= n_p1_last;
        r_p1_ovf  <= n_p1_ovf;
        if (w_adv && r_p1_valid) begin
            r_out_tag  <= esbk_pkg::OUT_TAG_W'(r_rd_data[ENT_W-1:KEY_BITS]);
            r_out_key  <= esbk_pkg::OUT_KEY_W'(r_rd_data[KEY_BITS-1:0]);
            r_out_ovf  <= r_p1_ovf;
            r_out_last <= r_p1_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_origin_index = r_out_tag;
    assign o_key_value    = r_out_key;
    assign o_overflowed   = r_out_ovf;
    assign o_last         = r_out_last;

endmodule

// File: design/exchange_sort_by_key.sv
`timescale 1ns / 1ps
// ============================================================================
// exchange_sort_by_key: list sorter with arrival tags
// Collects a list of keys, sorts it with an exchange sort and streams the
// entries out in ascending key order together with their arrival index.
// ============================================================================
// Words of a list are taken one per clock cycle while the command queue has
// room, and are written into a store of MAX_ENTRIES entries; words beyond that
// are dropped and every result of the list then carries the overflow flag in
// tuser. The word with tlast starts the sort, which compares one stored entry
// a cycle against a held candidate on a simple dual-port store (one read, one
// write per cycle); during the sort no new word is taken beyond the two the
// command queue holds. The results then leave at one per cycle while tready is
// high, the last with tlast, and loading of the next list resumes as soon as
// the final entry has been read out of the store.
module exchange_sort_by_key #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // key_value
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // origin_index, key_value_out, zero pad
    output logic        o_m_axis_tuser,   // overflowed
    output logic        o_m_axis_tlast
);

    localparam int TAG_W = $clog2(MAX_ENTRIES);
    localparam int CTL_W = $bits(esbk_pkg::t_cmd_ctl);
    localparam int QW    = CTL_W + TAG_W + KEY_BITS;

    logic                        w_push;
    logic                        w_full;
    esbk_pkg::t_cmd_ctl          w_f_ctl;
    logic [TAG_W-1:0]            w_f_tag;
    logic [KEY_BITS-1:0]         w_f_key;
    logic [QW-1:0]               w_q_in;
    logic [QW-1:0]               w_q_out;
    logic                        w_q_valid;
    logic                        w_pop;
    esbk_pkg::t_cmd_ctl          w_q_ctl;
    logic [TAG_W-1:0]            w_q_tag;
    logic [KEY_BITS-1:0]         w_q_key;
    logic [esbk_pkg::OUT_TAG_W-1:0] w_origin;
    logic [esbk_pkg::OUT_KEY_W-1:0] w_key_out;

    esbk_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_key_value (i_s_axis_tdata),
        .i_is_last   (i_s_axis_tlast),
        .o_push      (w_push),
        .i_full      (w_full),
        .o_ctl       (w_f_ctl),
        .o_tag       (w_f_tag),
        .o_key       (w_f_key)
    );

    assign w_q_in = {w_f_ctl, w_f_tag, w_f_key};

    esbk_queue #(
        .WIDTH (QW),
        .DEPTH (esbk_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    assign w_q_ctl = w_q_out[QW-1 -: CTL_W];
    assign w_q_tag = w_q_out[KEY_BITS +: TAG_W];
    assign w_q_key = w_q_out[KEY_BITS-1:0];

    esbk_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .o_q_pop        (w_pop),
        .i_q_ctl        (w_q_ctl),
        .i_q_tag        (w_q_tag),
        .i_q_key        (w_q_key),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_origin_index (w_origin),
        .o_key_value    (w_key_out),
        .o_overflowed   (o_m_axis_tuser),
        .o_last         (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, w_key_out, w_origin};

    a_pop_needs_entry : assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_pop |-> w_q_valid
    ) else $error("command taken from an empty queue");

    a_push_needs_room : assert property (
        @(posedge i_clk) disable iff (!i_rst_n) w_push |-> !w_full
    ) else $error("command written into a full queue");

    a_reset_clears_output : assert property (
        @(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid
    ) else $error("result word valid straight after reset");

    a_origin_in_range : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((MAX_ENTRIES >= 64) || (32'(o_m_axis_tdata[5:0]) < 32'(MAX_ENTRIES)))
    ) else $error("origin index beyond the store capacity");

endmodule
